@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the hash table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clk edge outside of reset.
`define ASSERT_PROP(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside of reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  `ASSERT_PROP(lbl, !(expr), msg)

`endif

@@ rtl/core/lpht_pkg.sv @@
// Types, constants and codes for the linear probing hash table.
package lpht_pkg;

  localparam int SLOTS = 256;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int M_W   = $clog2(SLOTS + 1);
  localparam int KEY_W = 8;
  localparam int VAL_W = 8;
  localparam int BC_W  = 9;
  localparam int OP_W  = 2;
  localparam int ST_W  = 2;

  localparam logic [BC_W-1:0] BC_RESET = BC_W'(256);

  localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
  localparam logic [OP_W-1:0] OP_GET    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL = 2'd1;
  localparam logic [ST_W-1:0] ST_MISS = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key_in;
    logic [VAL_W-1:0] value_in;
  } in_beat_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic             found;
    logic [VAL_W-1:0] value_out;
  } out_beat_t;

  typedef struct packed {
    logic      valid;
    out_beat_t beat;
  } res_t;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } slot_t;

endpackage

@@ rtl/core/lpht_mod.sv @@
// Bit-serial remainder unit: key modulo the active bucket count.
module lpht_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lpht_pkg::KEY_W-1:0] key,
  input  logic [lpht_pkg::M_W-1:0]   m,
  output logic                      done,
  output logic [lpht_pkg::KEY_W-1:0] rem
);
  import lpht_pkg::*;

  localparam int CNT_W = $clog2(KEY_W);
  localparam int CW    = (M_W > KEY_W + 1) ? M_W : KEY_W + 1;

  logic             run_r, run_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [KEY_W-1:0] bits_r, bits_nxt;
  logic [KEY_W-1:0] rem_r, rem_nxt;

  logic [KEY_W:0]   trial;
  logic [CW-1:0]    trial_w;
  logic [CW-1:0]    m_w;
  logic [CW-1:0]    diff;

  assign trial   = {rem_r, bits_r[KEY_W-1]};
  assign trial_w = CW'(trial);
  assign m_w     = CW'(m);
  assign diff    = trial_w - m_w;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    bits_nxt = bits_r;
    rem_nxt  = rem_r;
    if (start) begin
      run_nxt  = 1'b1;
      cnt_nxt  = '0;
      bits_nxt = key;
      rem_nxt  = '0;
    end else if (run_r) begin
      bits_nxt = {bits_r[KEY_W-2:0], 1'b0};
      rem_nxt  = (trial_w >= m_w) ? KEY_W'(diff) : trial[KEY_W-1:0];
      cnt_nxt  = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(KEY_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    bits_r <= bits_nxt;
    rem_r  <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

@@ rtl/core/lpht_ctrl.sv @@
// Probe sequencer and slot memory of the hash table.
`include "assert_macros.svh"

module lpht_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lpht_pkg::in_beat_t     in_data,
  input  logic [lpht_pkg::M_W-1:0] m,
  input  logic                   res_ready,
  output lpht_pkg::res_t         res
);
  import lpht_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HOME, S_PCHK, S_LCHK, S_SCHK, S_RHOME, S_RCHK, S_DONE
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] clr_r, clr_nxt;
  logic [M_W-1:0]   cnt_r, cnt_nxt;
  logic [OP_W-1:0]  op_r, op_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [M_W-1:0]   n_r, n_nxt;
  logic [IDX_W-1:0] sidx_r, sidx_nxt;
  logic [M_W-1:0]   sn_r, sn_nxt;
  logic [KEY_W-1:0] rk_r, rk_nxt;
  logic [VAL_W-1:0] rv_r, rv_nxt;
  out_beat_t        beat_r, beat_nxt;

  slot_t            mem [SLOTS];
  slot_t            rd_r;
  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  slot_t            mem_wd;
  logic [IDX_W-1:0] mem_ra;

  logic             mod_start;
  logic [KEY_W-1:0] mod_key;
  logic             mod_done;
  logic [KEY_W-1:0] mod_rem;

  logic [IDX_W-1:0] idx_step;
  logic [IDX_W-1:0] sidx_step;
  logic [M_W-1:0]   n_inc;

  function automatic logic [IDX_W-1:0] step_idx(input logic [IDX_W-1:0] i,
                                                input logic [M_W-1:0] mm);
    logic [M_W-1:0] s;
    s = M_W'(i) + M_W'(1);
    return (s >= mm) ? '0 : IDX_W'(s);
  endfunction

  lpht_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .key   (mod_key),
    .m     (m),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  assign idx_step  = step_idx(idx_r, m);
  assign sidx_step = step_idx(sidx_r, m);
  assign n_inc     = n_r + M_W'(1);
  assign in_stall  = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    op_nxt    = op_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    idx_nxt   = idx_r;
    n_nxt     = n_r;
    sidx_nxt  = sidx_r;
    sn_nxt    = sn_r;
    rk_nxt    = rk_r;
    rv_nxt    = rv_r;
    beat_nxt  = beat_r;
    mem_we    = 1'b0;
    mem_wa    = idx_r;
    mem_wd    = '0;
    mem_ra    = idx_r;
    mod_start = 1'b0;
    mod_key   = key_r;
    res       = '0;
    res.beat  = beat_r;

    unique case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = clr_r;
        clr_nxt = clr_r + IDX_W'(1);
        if (clr_r == IDX_W'(SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt   = in_data.operation;
          key_nxt  = in_data.key_in;
          val_nxt  = in_data.value_in;
          beat_nxt = '0;
          mod_key  = in_data.key_in;
          unique case (in_data.operation)
            OP_PUT: begin
              if (cnt_r >= m - M_W'(1)) begin
                beat_nxt.status = ST_FULL;
                state_nxt       = S_DONE;
              end else begin
                mod_start = 1'b1;
                state_nxt = S_HOME;
              end
            end
            OP_GET, OP_REMOVE: begin
              mod_start = 1'b1;
              state_nxt = S_HOME;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_HOME: begin
        if (mod_done) begin
          idx_nxt   = IDX_W'(mod_rem);
          n_nxt     = '0;
          mem_ra    = IDX_W'(mod_rem);
          state_nxt = (op_r == OP_PUT) ? S_PCHK : S_LCHK;
        end
      end
      S_PCHK: begin
        if (!rd_r.valid) begin
          mem_we    = 1'b1;
          mem_wd    = '{valid: 1'b1, key: key_r, value: val_r};
          cnt_nxt   = cnt_r + M_W'(1);
          state_nxt = S_DONE;
        end else if (n_inc == m) begin
          cnt_nxt   = cnt_r + M_W'(1);
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_step;
          n_nxt   = n_inc;
          mem_ra  = idx_step;
        end
      end
      S_LCHK: begin
        if (!rd_r.valid) begin
          beat_nxt.status = ST_MISS;
          state_nxt       = S_DONE;
        end else if (rd_r.key == key_r) begin
          if (op_r == OP_GET) begin
            beat_nxt.found     = 1'b1;
            beat_nxt.value_out = rd_r.value;
            state_nxt          = S_DONE;
          end else begin
            mem_we    = 1'b1;
            cnt_nxt   = cnt_r - M_W'(1);
            sidx_nxt  = idx_step;
            sn_nxt    = '0;
            mem_ra    = idx_step;
            state_nxt = S_SCHK;
          end
        end else if (n_inc == m) begin
          beat_nxt.status = ST_MISS;
          state_nxt       = S_DONE;
        end else begin
          idx_nxt = idx_step;
          n_nxt   = n_inc;
          mem_ra  = idx_step;
        end
      end
      S_SCHK: begin
        if (sn_r == m || !rd_r.valid) begin
          state_nxt = S_DONE;
        end else begin
          rk_nxt    = rd_r.key;
          rv_nxt    = rd_r.value;
          mem_we    = 1'b1;
          mem_wa    = sidx_r;
          mod_start = 1'b1;
          mod_key   = rd_r.key;
          state_nxt = S_RHOME;
        end
      end
      S_RHOME: begin
        if (mod_done) begin
          idx_nxt   = IDX_W'(mod_rem);
          n_nxt     = '0;
          mem_ra    = IDX_W'(mod_rem);
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (!rd_r.valid || n_inc == m) begin
          if (!rd_r.valid) begin
            mem_we = 1'b1;
            mem_wd = '{valid: 1'b1, key: rk_r, value: rv_r};
          end
          sidx_nxt  = sidx_step;
          sn_nxt    = sn_r + M_W'(1);
          mem_ra    = sidx_step;
          state_nxt = S_SCHK;
        end else begin
          idx_nxt = idx_step;
          n_nxt   = n_inc;
          mem_ra  = idx_step;
        end
      end
      S_DONE: begin
        if (res_ready) begin
          res.valid = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_we && mem_wa == mem_ra) begin
      rd_r <= mem_wd;
    end else begin
      rd_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
    end
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    idx_r  <= idx_nxt;
    n_r    <= n_nxt;
    sidx_r <= sidx_nxt;
    sn_r   <= sn_nxt;
    rk_r   <= rk_nxt;
    rv_r   <= rv_nxt;
    beat_r <= beat_nxt;
  end

  `ASSERT_PROP(a_cnt_bound, cnt_r <= M_W'(SLOTS), "entry count beyond slot total")
  `ASSERT_PROP(a_mod_wait, mod_done |-> (state_r == S_HOME || state_r == S_RHOME), "stray done")
  `ASSERT_NEVER(a_idle_write, mem_we && (state_r == S_IDLE || state_r == S_DONE), "idle write")

endmodule

@@ rtl/core/linear_probe_hash_table.sv @@
// Top level of the linear probing hash table: config register, output register.
//
// Input beats (operation, key_in, value_in) arrive on in_valid / in_stall and
// one result beat (status, found, value_out) leaves on out_valid / out_stall
// for every input beat, in order. cfg_we / cfg_wdata write bucket_count, the
// hash modulus, saturated to 2..256; write it only while the table is idle.
//
// After rst_n the slot memory is swept clear, one slot a cycle, while in_stall
// stays high; then the table is empty and bucket_count is 256.
//
// Flow: for a get or put, the home slot comes from a bit-serial remainder unit,
// then each probe is one read of the slot memory until the walk ends. A remove
// also pulls every entry that follows in the cluster, finds its home slot the
// same way and probes again for its reinsertion. A full put or an unused code
// goes straight to the result. One operation is in flight at a time; the next
// beat is taken the cycle after the result is loaded, so a new beat is never
// taken before the last one is through. A new beat is taken while the last
// result still sits in the output register. A stalled result holds, and the
// next result waits inside the sequencer until the register frees.
`include "assert_macros.svh"

module linear_probe_hash_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  lpht_pkg::in_beat_t          in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output lpht_pkg::out_beat_t         out_data,
  input  logic                        cfg_we,
  input  logic [lpht_pkg::BC_W-1:0]   cfg_wdata
);
  import lpht_pkg::*;

  logic [BC_W-1:0] bc_r;
  logic [M_W-1:0]  m;
  logic            out_valid_r;
  out_beat_t       out_data_r;
  logic            res_ready;
  res_t            res;

  always_comb begin
    if (bc_r < BC_W'(2)) begin
      m = M_W'(2);
    end else if (32'(bc_r) > 32'(SLOTS)) begin
      m = M_W'(SLOTS);
    end else begin
      m = M_W'(bc_r);
    end
  end

  assign res_ready = !out_valid_r || !out_stall;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .m         (m),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r        <= BC_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        bc_r <= cfg_wdata;
      end
      if (res.valid) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      out_data_r <= res.beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_PROP(a_no_overwrite, res.valid |-> !(out_valid_r && out_stall), "result beat dropped")

endmodule

@@ bench/linear_probe_hash_table_tb.sv @@
// Self-checking bench for the linear probing hash table: directed rows, then random phases.
`timescale 1ns / 1ps

module linear_probe_hash_table_tb;
  import lpht_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASE_ITEMS = 28;
  localparam int NUM_PHASES  = 12;
  localparam int KEEP_PHASE  = 1;  // entering this phase keeps stale contents
  localparam logic [BC_W-1:0] PHASE_BC [NUM_PHASES] = '{
    9'd511, 9'd8, 9'd300, 9'd2, 9'd0, 9'd1, 9'd3, 9'd256, 9'd5, 9'd64, 9'd17, 9'd257
  };

  localparam out_beat_t BEAT_OK   = '{status: ST_OK,   found: 1'b0, value_out: '0};
  localparam out_beat_t BEAT_FULL = '{status: ST_FULL, found: 1'b0, value_out: '0};
  localparam out_beat_t BEAT_MISS = '{status: ST_MISS, found: 1'b0, value_out: '0};

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    in_beat_t         beat;
    logic [BC_W-1:0]  bc;
    logic             known;
    out_beat_t        want;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_beat_t out_data;
  logic      cfg_we;
  logic [BC_W-1:0] cfg_wdata;

  // table model
  logic             tbl_used [SLOTS];
  logic [KEY_W-1:0] tbl_key [SLOTS];
  logic [VAL_W-1:0] tbl_val [SLOTS];
  logic [BC_W-1:0]  tbl_count;
  logic [BC_W-1:0]  bucket_cfg;

  out_beat_t pending_results [$];
  int        err_cnt;
  int        cycle_cnt;
  logic      no_idle;

  linear_probe_hash_table u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic int active_buckets();
    int m;
    m = int'(bucket_cfg);
    if (m < 2) m = 2;
    if (m > SLOTS) m = SLOTS;
    return m;
  endfunction

  function automatic int step_slot(int i, int m);
    return (i + 1 >= m) ? 0 : i + 1;
  endfunction

  function automatic int find_key(logic [KEY_W-1:0] k, int m);
    int i;
    i = int'(k) % m;
    for (int n = 0; n < m; n++) begin
      if (!tbl_used[i]) return m;
      if (tbl_key[i] == k) return i;
      i = step_slot(i, m);
    end
    return m;
  endfunction

  function automatic void settle_entry(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v, int m);
    int i;
    i = int'(k) % m;
    for (int n = 0; n < m; n++) begin
      if (!tbl_used[i]) begin
        tbl_used[i] = 1'b1;
        tbl_key[i]  = k;
        tbl_val[i]  = v;
        return;
      end
      i = step_slot(i, m);
    end
  endfunction

  function automatic out_beat_t predict_hash_op(in_beat_t b);
    int m;
    int i;
    int n;
    logic [KEY_W-1:0] rk;
    logic [VAL_W-1:0] rv;
    out_beat_t r;
    m = active_buckets();
    r = BEAT_OK;
    case (b.operation)
      OP_PUT: begin
        if (int'(tbl_count) >= m - 1) begin
          r.status = ST_FULL;
        end else begin
          settle_entry(b.key_in, b.value_in, m);
          tbl_count = tbl_count + 1'b1;
        end
      end
      OP_GET: begin
        i = find_key(b.key_in, m);
        if (i < m) begin
          r.found     = 1'b1;
          r.value_out = tbl_val[i];
        end else begin
          r.status = ST_MISS;
        end
      end
      OP_REMOVE: begin
        i = find_key(b.key_in, m);
        if (i < m) begin
          tbl_used[i] = 1'b0;
          tbl_count   = tbl_count - 1'b1;
          i = step_slot(i, m);
          n = 0;
          // pull the rest of the cluster and place it again
          while (n < m && tbl_used[i]) begin
            rk = tbl_key[i];
            rv = tbl_val[i];
            tbl_used[i] = 1'b0;
            settle_entry(rk, rv, m);
            i = step_slot(i, m);
            n++;
          end
        end else begin
          r.status = ST_MISS;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [KEY_W-1:0] pick_key(int m, int hub);
    int r;
    int start;
    int idx;
    r = $urandom_range(0, 9);
    if (r < 4 && tbl_count != 0) begin
      start = $urandom_range(0, SLOTS - 1);
      for (int n = 0; n < SLOTS; n++) begin
        idx = (start + n) % SLOTS;
        if (tbl_used[idx]) return tbl_key[idx];
      end
    end
    if (r < 8) return KEY_W'(hub + m * $urandom_range(0, 3) + $urandom_range(0, 2));
    return KEY_W'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t op_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                       logic [VAL_W-1:0] v);
    stim_row_t r;
    r = '0;
    r.kind = ROW_BEAT;
    r.beat.operation = op;
    r.beat.key_in    = k;
    r.beat.value_in  = v;
    return r;
  endfunction

  function automatic stim_row_t known_row(logic [OP_W-1:0] op, logic [KEY_W-1:0] k,
                                          logic [VAL_W-1:0] v, out_beat_t want);
    stim_row_t r;
    r = op_row(op, k, v);
    r.known = 1'b1;
    r.want  = want;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [BC_W-1:0] bc);
    stim_row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.bc   = bc;
    return r;
  endfunction

  // starts and ends at a falling edge; valid stays up for back-to-back beats
  task automatic send_beat(in_beat_t b, logic known, out_beat_t want);
    int gap;
    out_beat_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = b;
    do @(posedge clk); while (in_stall);
    pred = predict_hash_op(b);
    pending_results.push_back(known ? want : pred);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_bucket(logic [BC_W-1:0] bc);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = bc;
    @(negedge clk);
    cfg_we     = 1'b0;
    bucket_cfg = bc;
  endtask

  task automatic drain_table();
    logic [KEY_W-1:0] keys [$];
    in_beat_t b;
    for (int i = 0; i < SLOTS; i++) begin
      if (tbl_used[i]) keys.push_back(tbl_key[i]);
    end
    foreach (keys[j]) begin
      b.operation = OP_REMOVE;
      b.key_in    = keys[j];
      b.value_in  = KEY_W'($urandom_range(0, 255));
      send_beat(b, 1'b0, BEAT_OK);
    end
  endtask

  // result side: random stall per beat
  initial begin
    int n;
    out_stall = 1'b0;
    wait (rst_n);
    forever begin
      n = no_idle ? 0 : $urandom_range(0, 6);
      repeat (n) begin
        @(negedge clk);
        out_stall = 1'b1;
      end
      @(negedge clk);
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        err_cnt++;
        $display("%0t: unexpected beat status=%0d found=%0d value=%02h", $time,
                 out_data.status, out_data.found, out_data.value_out);
      end else begin
        want = pending_results.pop_front();
        if (out_data.status !== want.status || out_data.found !== want.found ||
            out_data.value_out !== want.value_out) begin
          err_cnt++;
          $display("%0t: exp status=%0d found=%0d value=%02h, %s%0d found=%0d value=%02h",
                   $time, want.status, want.found, want.value_out, "got status=",
                   out_data.status, out_data.found, out_data.value_out);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    stim_row_t dir_rows [$];
    in_beat_t b;
    int m;
    int hub;
    int r;
    err_cnt    = 0;
    cycle_cnt  = 0;
    no_idle    = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    tbl_count  = '0;
    bucket_cfg = BC_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_val[i]  = '0;
    end

    dir_rows = '{
      known_row(OP_GET,    8'h00, 8'h00, BEAT_MISS),
      known_row(OP_REMOVE, 8'hFF, 8'hFF, BEAT_MISS),
      known_row(OP_UNUSED, 8'hAA, 8'h55, BEAT_OK),
      op_row(OP_PUT,    8'h00, 8'hFF),
      op_row(OP_PUT,    8'hFF, 8'h00),
      op_row(OP_PUT,    8'h00, 8'h5A),   // duplicate key
      op_row(OP_PUT,    8'h01, 8'h11),
      op_row(OP_GET,    8'h00, 8'h00),
      op_row(OP_GET,    8'hFF, 8'h00),
      op_row(OP_REMOVE, 8'h00, 8'h00),   // cluster shifts back
      op_row(OP_GET,    8'h00, 8'h00),
      op_row(OP_GET,    8'h01, 8'h00),
      cfg_row(9'd2),
      known_row(OP_PUT, 8'h07, 8'h07, BEAT_FULL),
      op_row(OP_GET,    8'h04, 8'h00),   // every slot taken, walk ends at m
      op_row(OP_GET,    8'h01, 8'h00),
      cfg_row(9'd0),
      op_row(OP_REMOVE, 8'h00, 8'h00),
      cfg_row(9'd1),
      op_row(OP_GET,    8'h00, 8'h00),
      cfg_row(9'd257),
      op_row(OP_GET,    8'hFF, 8'h00),
      op_row(OP_REMOVE, 8'hFF, 8'h00),
      op_row(OP_GET,    8'hFF, 8'h00)
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_bucket(dir_rows[i].bc);
      end else begin
        send_beat(dir_rows[i].beat, dir_rows[i].known, dir_rows[i].want);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p != KEEP_PHASE) drain_table();
      write_bucket(PHASE_BC[p]);
      no_idle = ($urandom_range(0, 3) == 0);
      m   = active_buckets();
      hub = $urandom_range(0, m - 1);
      repeat (PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0) no_idle = ~no_idle;
        r = $urandom_range(0, 99);
        b.operation = (r < 45) ? OP_PUT : (r < 75) ? OP_GET : (r < 95) ? OP_REMOVE : OP_UNUSED;
        b.key_in    = pick_key(m, hub);
        b.value_in  = VAL_W'($urandom_range(0, 255));
        send_beat(b, 1'b0, BEAT_OK);
      end
    end

    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
